### hw/rtl/pblru_pkg.sv
// pblru_pkg: shared types, field widths and status codes for the page buffer
// lru tag manager. No dependencies.
package pblru_pkg;

  localparam int POOL_SLOTS_DEF = 16;

  localparam int ACTION_W = 1;
  localparam int TABLE_W  = 10;
  localparam int PAGE_W   = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // request actions
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_READ_HIT     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FILLED       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CLEAN_EVICT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIRTY_EVICT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_WRITE_MARKED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_WRITE_MISS   = 3'd5;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [TABLE_W-1:0]  tbl_id;
    logic [PAGE_W-1:0]   page_no;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [TABLE_W-1:0]  victim_tbl_id;
    logic [PAGE_W-1:0]   victim_page_no;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch request
    logic scan;       // tag data for current index is valid
    logic rd_victim;  // read tag memory at victim index
    logic commit;     // finish hit, fill or write miss
    logic evict;      // finish eviction
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_hit;
    logic scan_empty;
    logic req_write;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/pblru_dp.sv
// pblru_dp: tag memory, valid/dirty/rank state, victim tracking and the
// result register. Depends on pblru_pkg; driven by pblru_ctrl commands.
module pblru_dp #(
  parameter int POOL_SLOTS = pblru_pkg::POOL_SLOTS_DEF,
  parameter int IDX_W      = $clog2(POOL_SLOTS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pblru_pkg::req_t   in_data,
  input  pblru_pkg::cmd_t   cmd,
  input  logic [IDX_W-1:0]  cur_idx,
  input  logic [IDX_W-1:0]  rd_idx,
  output pblru_pkg::sts_t   sts,
  output logic              out_valid,
  input  logic              out_stall,
  output pblru_pkg::rsp_t   out_data
);
  import pblru_pkg::*;

  localparam int TagW = TABLE_W + PAGE_W;

  logic [TagW-1:0]       tag_mem [POOL_SLOTS];
  logic [TagW-1:0]       rdata_r;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;
  logic                  mem_we;

  logic [POOL_SLOTS-1:0] valid_r, valid_nxt;
  logic [POOL_SLOTS-1:0] dirty_r, dirty_nxt;
  logic [IDX_W-1:0]      rank_r   [POOL_SLOTS];
  logic [IDX_W-1:0]      rank_nxt [POOL_SLOTS];

  req_t                  req_r;
  logic [TagW-1:0]       req_tag;
  logic [IDX_W-1:0]      fidx_r;
  logic                  fhit_r, fempty_r;
  logic [IDX_W-1:0]      best_r, best_nxt;

  logic                  scan_hit, scan_empty;
  logic                  is_write;
  logic                  fill;
  logic                  mr_en, mr_fresh;
  logic [IDX_W-1:0]      mr_slot, mr_old;

  logic                  out_valid_r;
  rsp_t                  out_data_r, rsp_nxt;
  logic                  out_free;

  assign req_tag  = {req_r.tbl_id, req_r.page_no};
  assign is_write = (req_r.action == ACT_WRITE);
  assign fill     = cmd.commit && !is_write && fempty_r;

  // tag memory: one write port, one registered read port
  assign rd_addr = cmd.rd_victim ? best_r : rd_idx;
  assign wr_addr = cmd.evict ? best_r : fidx_r;
  assign mem_we  = fill || cmd.evict;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[wr_addr] <= req_tag;
    end
    rdata_r <= tag_mem[rd_addr];
  end

  // lookup of the slot whose tags arrive this cycle
  assign scan_empty = !valid_r[cur_idx];
  assign scan_hit   = valid_r[cur_idx] && (rdata_r == req_tag);

  // oldest usable slot seen so far
  always_comb begin
    best_nxt = best_r;
    if (cmd.scan) begin
      if ((cur_idx == '0) || (rank_r[cur_idx] > rank_r[best_r])) begin
        best_nxt = cur_idx;
      end
    end
  end

  // recency update
  assign mr_en    = cmd.evict || (cmd.commit && !is_write && (fhit_r || fempty_r));
  assign mr_fresh = fill;
  assign mr_slot  = cmd.evict ? best_r : fidx_r;
  assign mr_old   = rank_r[mr_slot];

  always_comb begin
    for (int i = 0; i < POOL_SLOTS; i++) begin
      rank_nxt[i] = rank_r[i];
      if (mr_en) begin
        if (IDX_W'(i) == mr_slot) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (mr_fresh || (rank_r[i] < mr_old))) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    if (cmd.commit && fhit_r && is_write) begin
      dirty_nxt[fidx_r] = 1'b1;
    end
    if (fill) begin
      valid_nxt[fidx_r] = 1'b1;
      dirty_nxt[fidx_r] = 1'b0;
    end
    if (cmd.evict) begin
      dirty_nxt[best_r] = 1'b0;
    end
  end

  // result
  always_comb begin
    rsp_nxt = '0;
    if (cmd.evict) begin
      rsp_nxt.status         = dirty_r[best_r] ? ST_DIRTY_EVICT : ST_CLEAN_EVICT;
      rsp_nxt.slot           = SLOT_W'(best_r);
      rsp_nxt.victim_tbl_id  = rdata_r[TagW-1:PAGE_W];
      rsp_nxt.victim_page_no = rdata_r[PAGE_W-1:0];
    end else if (fhit_r) begin
      rsp_nxt.status = is_write ? ST_WRITE_MARKED : ST_READ_HIT;
      rsp_nxt.slot   = SLOT_W'(fidx_r);
    end else if (fempty_r && !is_write) begin
      rsp_nxt.status = ST_FILLED;
      rsp_nxt.slot   = SLOT_W'(fidx_r);
    end else begin
      rsp_nxt.status = ST_WRITE_MISS;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      dirty_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      if (cmd.commit || cmd.evict) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
    best_r <= best_nxt;
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.scan) begin
      fidx_r   <= cur_idx;
      fhit_r   <= scan_hit;
      fempty_r <= scan_empty;
    end
    if (cmd.commit || cmd.evict) begin
      out_data_r <= rsp_nxt;
    end
  end

  assign sts.scan_hit   = scan_hit;
  assign sts.scan_empty = scan_empty;
  assign sts.req_write  = is_write;
  assign sts.out_free   = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit || cmd.evict) |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while held");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.scan, cmd.rd_victim, cmd.commit, cmd.evict}))
    else $error("more than one datapath command");

  a_victim_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.evict |-> valid_r[best_r])
    else $error("eviction of an empty slot");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit || cmd.evict) |=> out_valid_r)
    else $error("finished request produced no result");

endmodule

### hw/rtl/pblru_ctrl.sv
// pblru_ctrl: request sequencer and slot limit register.
// Depends on pblru_pkg; drives pblru_dp through cmd_t, reads sts_t.
module pblru_ctrl #(
  parameter int POOL_SLOTS = pblru_pkg::POOL_SLOTS_DEF,
  parameter int IDX_W      = $clog2(POOL_SLOTS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cfg_we,
  input  logic [pblru_pkg::CFG_W-1:0]  cfg_wdata,
  input  pblru_pkg::sts_t              sts,
  output pblru_pkg::cmd_t              cmd,
  output logic [IDX_W-1:0]             cur_idx,
  output logic [IDX_W-1:0]             rd_idx
);
  import pblru_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DONE  = 3'd2;
  localparam logic [2:0] S_VRD   = 3'd3;
  localparam logic [2:0] S_EVICT = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [CFG_W-1:0] cfg_r;
  logic [IDX_W-1:0] lim_last;
  logic             accept;

  // last usable slot index, limit clamped to 1..POOL_SLOTS
  always_comb begin
    if (cfg_r == '0) begin
      lim_last = '0;
    end else if (32'(cfg_r) > 32'(POOL_SLOTS)) begin
      lim_last = IDX_W'(POOL_SLOTS - 1);
    end else begin
      lim_last = IDX_W'(cfg_r - 1'b1);
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign cur_idx  = cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    rd_idx    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        rd_idx   = cnt_r + 1'b1;
        if (sts.scan_hit || sts.scan_empty) begin
          state_nxt = S_DONE;
        end else if (cnt_r == lim_last) begin
          state_nxt = sts.req_write ? S_DONE : S_VRD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_VRD: begin
        cmd.rd_victim = 1'b1;
        state_nxt     = S_EVICT;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_EVICT: begin
        if (sts.out_free) begin
          cmd.evict = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          // keep the victim tags in the read register while the result waits
          cmd.rd_victim = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cfg_r   <= CFG_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r <= lim_last))
    else $error("scan index beyond usable slots");

  a_capture_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_SCAN) && (cnt_r == '0))
    else $error("accepted request did not start at slot zero");

  a_victim_read_before_evict: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_victim |=> (state_r == S_EVICT))
    else $error("victim read not followed by eviction");

endmodule

### hw/rtl/page_buffer_lru_tag_manager.sv
// page_buffer_lru_tag_manager: top level of the page buffer tag and lru
// replacement controller. Depends on pblru_pkg, pblru_ctrl and pblru_dp.
//
//   channel | ports                        | direction | transaction when
//   --------+------------------------------+-----------+----------------------------
//   in      | in_valid, in_stall, in_data  | input     | in_valid && !in_stall
//   out     | out_valid, out_stall, out_data | output  | out_valid && !out_stall
//   cfg     | cfg_we, cfg_wdata            | input     | cfg_we (slot limit register)
//
// one request at a time: an accept step, then the slots are scanned in order
// (tag memory has a single registered read port), then a finish step; a read miss
// on a full pool adds a victim tag read step before the finish step.
// reset is synchronous on rst_n: all slots empty and clean, limit set to 16.
// a waiting result sits in an output register; the finish step waits only
// while that register is full and out_stall is high. in_stall is high from
// accept until the request's result is written into the output register.
module page_buffer_lru_tag_manager #(
  parameter int POOL_SLOTS = pblru_pkg::POOL_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  pblru_pkg::req_t              in_data,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output pblru_pkg::rsp_t              out_data,
  // slot limit register
  input  logic                         cfg_we,
  input  logic [pblru_pkg::CFG_W-1:0]  cfg_wdata
);
  import pblru_pkg::*;

  localparam int IdxW = $clog2(POOL_SLOTS);

  cmd_t            cmd;
  sts_t            sts;
  logic [IdxW-1:0] cur_idx;
  logic [IdxW-1:0] rd_idx;

  // sequencer: walks slots 0..limit-1, picks the finish path
  pblru_ctrl #(
    .POOL_SLOTS (POOL_SLOTS),
    .IDX_W      (IdxW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .cmd       (cmd),
    .cur_idx   (cur_idx),
    .rd_idx    (rd_idx)
  );

  // tags, recency ranks, victim search and result register
  pblru_dp #(
    .POOL_SLOTS (POOL_SLOTS),
    .IDX_W      (IdxW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .cur_idx   (cur_idx),
    .rd_idx    (rd_idx),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
